// File: rtl/swlc_pkg.sv
// ----------------------------------------------------------------------------
// swlc_pkg
// Shared types and codes for the stop-and-wait link controller.
// ----------------------------------------------------------------------------
package swlc_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int LIMIT_W         = 8;
  localparam int CFG_DATA_W      = 8;
  localparam int CFG_ADDR_W      = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ROLE         = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_LIMIT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ANSWER_LIMIT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ASSUME_OK    = 2'd3;

  localparam logic [LIMIT_W-1:0] TIME_LIMIT_RST   = 8'd3;
  localparam logic [LIMIT_W-1:0] ANSWER_LIMIT_RST = 8'd3;

  // opcodes
  localparam logic [3:0] OP_OPEN     = 4'd0;
  localparam logic [3:0] OP_CLOSE    = 4'd1;
  localparam logic [3:0] OP_WRITE    = 4'd2;
  localparam logic [3:0] OP_READ     = 4'd3;
  localparam logic [3:0] OP_WR_OK    = 4'd4;
  localparam logic [3:0] OP_WR_FAIL  = 4'd5;
  localparam logic [3:0] OP_FRM_OK   = 4'd6;
  localparam logic [3:0] OP_FRM_BAD  = 4'd7;
  localparam logic [3:0] OP_TIMEOUT  = 4'd8;

  // received frame kinds
  localparam logic [2:0] RX_SET  = 3'd0;
  localparam logic [2:0] RX_UA   = 3'd1;
  localparam logic [2:0] RX_DISC = 3'd2;
  localparam logic [2:0] RX_I    = 3'd3;
  localparam logic [2:0] RX_RR   = 3'd4;
  localparam logic [2:0] RX_REJ  = 3'd5;

  // frames to send
  localparam logic [2:0] TX_NONE = 3'd0;
  localparam logic [2:0] TX_SET  = 3'd1;
  localparam logic [2:0] TX_UA   = 3'd2;
  localparam logic [2:0] TX_DISC = 3'd3;
  localparam logic [2:0] TX_I    = 3'd4;
  localparam logic [2:0] TX_RR   = 3'd5;
  localparam logic [2:0] TX_REJ  = 3'd6;

  // completion status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TIME   = 2'd1;
  localparam logic [1:0] ST_ANSWER = 2'd2;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_OT_WR   = 12'b0000_0000_0010,
    PH_OT_RD   = 12'b0000_0000_0100,
    PH_OR_RD   = 12'b0000_0000_1000,
    PH_CT_WR   = 12'b0000_0001_0000,
    PH_CT_RD   = 12'b0000_0010_0000,
    PH_CR_DISC = 12'b0000_0100_0000,
    PH_CR_WR   = 12'b0000_1000_0000,
    PH_CR_ANS  = 12'b0001_0000_0000,
    PH_W_WR    = 12'b0010_0000_0000,
    PH_W_RD    = 12'b0100_0000_0000,
    PH_R_RD    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] frame_kind;
    logic       frame_seq;
  } item_t;

  typedef struct packed {
    logic [2:0] send_kind;
    logic       send_seq;
    logic       await_write;
    logic       done_res;
    logic [1:0] status;
    logic       delivered;
  } result_t;

  typedef struct packed {
    logic               role;
    logic [LIMIT_W-1:0] time_limit;
    logic [LIMIT_W-1:0] answer_limit;
    logic               assume_ok;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   testing_peer;
    logic   tx_sequence;
    logic   rx_sequence;
  } ctrl_t;

endpackage

// File: rtl/swlc_stream_if.sv
// ----------------------------------------------------------------------------
// swlc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface swlc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/swlc_core.sv
// ----------------------------------------------------------------------------
// swlc_core
// Next-state and result logic for one event of the link controller.
// ----------------------------------------------------------------------------
module swlc_core #(
  parameter int COUNT_WIDTH = swlc_pkg::COUNT_WIDTH_DEF
) (
  input  swlc_pkg::cfg_t          cfg,
  input  swlc_pkg::item_t         item,
  input  swlc_pkg::ctrl_t         ctrl,
  input  logic [COUNT_WIDTH-1:0]  timeout_count,
  input  logic [COUNT_WIDTH-1:0]  bad_answer_count,
  output swlc_pkg::ctrl_t         ctrl_next,
  output logic [COUNT_WIDTH-1:0]  timeout_count_next,
  output logic [COUNT_WIDTH-1:0]  bad_answer_count_next,
  output logic                    emit,
  output swlc_pkg::result_t       res
);
  import swlc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [1:0] limits(input logic [COUNT_WIDTH-1:0] t,
                                        input logic [COUNT_WIDTH-1:0] b,
                                        input logic [LIMIT_W-1:0] tl,
                                        input logic [LIMIT_W-1:0] al);
    logic [1:0] s;
    s = ST_OK;
    if (CMP_W'(t) >= CMP_W'(tl)) begin
      s = ST_TIME;
    end else if (CMP_W'(b) >= CMP_W'(al)) begin
      s = ST_ANSWER;
    end
    return s;
  endfunction

  logic [COUNT_WIDTH-1:0] tc_inc;
  logic [COUNT_WIDTH-1:0] bc_inc;
  logic [1:0]             st_time;
  logic [1:0]             st_ans;
  logic [1:0]             st_zero;
  logic                   fok;
  logic                   finv;
  logic                   ftmo;
  logic                   wok;
  logic                   wfail;
  logic                   is_cmd;

  assign tc_inc  = (timeout_count == CMAX) ? timeout_count : timeout_count + 1'b1;
  assign bc_inc  = (bad_answer_count == CMAX) ? bad_answer_count : bad_answer_count + 1'b1;
  assign st_time = limits(tc_inc, bad_answer_count, cfg.time_limit, cfg.answer_limit);
  assign st_ans  = limits(timeout_count, bc_inc, cfg.time_limit, cfg.answer_limit);
  assign st_zero = limits('0, '0, cfg.time_limit, cfg.answer_limit);
  assign is_cmd  = (item.opcode <= OP_READ);
  assign wok     = (item.opcode == OP_WR_OK);
  assign wfail   = (item.opcode == OP_WR_FAIL);
  assign fok     = (item.opcode == OP_FRM_OK);
  assign finv    = (item.opcode == OP_FRM_BAD);
  assign ftmo    = (item.opcode == OP_TIMEOUT);

  logic       do_cont;
  logic       do_fin;
  logic [1:0] c_st;
  logic [2:0] c_kind;
  logic       c_seq;
  phase_t     c_ph;
  logic [2:0] f_kind;
  logic       f_seq;
  logic [1:0] f_st;
  logic       f_dl;

  always_comb begin
    ctrl_next             = ctrl;
    timeout_count_next    = timeout_count;
    bad_answer_count_next = bad_answer_count;
    emit                  = 1'b0;
    res                   = '0;
    do_cont = 1'b0;
    do_fin  = 1'b0;
    c_st    = ST_OK;
    c_kind  = TX_NONE;
    c_seq   = 1'b0;
    c_ph    = ctrl.phase;
    f_kind  = TX_NONE;
    f_seq   = 1'b0;
    f_st    = ST_OK;
    f_dl    = 1'b0;

    if (ctrl.phase == PH_IDLE) begin
      if (is_cmd) begin
        timeout_count_next    = '0;
        bad_answer_count_next = '0;
        ctrl_next.testing_peer = 1'b0;
        do_cont = 1'b1;
        c_st    = st_zero;
        case (item.opcode)
          OP_OPEN: begin
            c_kind = cfg.role ? TX_NONE : TX_SET;
            c_ph   = cfg.role ? PH_OR_RD : PH_OT_WR;
          end
          OP_CLOSE: begin
            c_kind = cfg.role ? TX_NONE : TX_DISC;
            c_ph   = cfg.role ? PH_CR_DISC : PH_CT_WR;
          end
          OP_WRITE: begin
            c_kind = TX_I;
            c_seq  = ctrl.tx_sequence;
            c_ph   = PH_W_WR;
          end
          default: begin
            c_ph = PH_R_RD;
          end
        endcase
      end
    end else if (!is_cmd) begin
      case (ctrl.phase)
        PH_OT_WR, PH_CT_WR, PH_W_WR: begin
          if (wok) begin
            case (ctrl.phase)
              PH_OT_WR: ctrl_next.phase = PH_OT_RD;
              PH_CT_WR: ctrl_next.phase = PH_CT_RD;
              default:  ctrl_next.phase = PH_W_RD;
            endcase
          end else if (wfail) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_ph    = ctrl.phase;
            case (ctrl.phase)
              PH_OT_WR: c_kind = TX_SET;
              PH_CT_WR: c_kind = TX_DISC;
              default: begin
                c_kind = TX_I;
                c_seq  = ctrl.tx_sequence;
              end
            endcase
          end
        end
        PH_OT_RD: begin
          if (fok && item.frame_kind == RX_UA) begin
            do_fin = 1'b1;
          end else if (fok || finv) begin
            if (cfg.assume_ok) begin
              do_fin = 1'b1;
            end else begin
              bad_answer_count_next = bc_inc;
              do_cont = 1'b1;
              c_st    = st_ans;
              c_kind  = TX_SET;
              c_ph    = PH_OT_WR;
            end
          end else if (ftmo) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_kind  = TX_SET;
            c_ph    = PH_OT_WR;
          end
        end
        PH_CT_RD: begin
          if (fok && item.frame_kind == RX_DISC) begin
            do_fin = 1'b1;
            f_kind = TX_UA;
          end else if (fok || finv) begin
            bad_answer_count_next = bc_inc;
            do_cont = 1'b1;
            c_st    = st_ans;
            c_kind  = TX_DISC;
            c_ph    = PH_CT_WR;
          end else if (ftmo) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_kind  = TX_DISC;
            c_ph    = PH_CT_WR;
          end
        end
        PH_W_RD: begin
          if (fok && (item.frame_kind == RX_RR || item.frame_kind == RX_REJ) &&
              item.frame_seq == !ctrl.tx_sequence) begin
            ctrl_next.tx_sequence = !ctrl.tx_sequence;
            do_fin = 1'b1;
          end else if (fok || finv) begin
            bad_answer_count_next = bc_inc;
            do_cont = 1'b1;
            c_st    = st_ans;
            c_kind  = TX_I;
            c_seq   = ctrl.tx_sequence;
            c_ph    = PH_W_WR;
          end else if (ftmo) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_kind  = TX_I;
            c_seq   = ctrl.tx_sequence;
            c_ph    = PH_W_WR;
          end
        end
        PH_OR_RD: begin
          if (fok && item.frame_kind == RX_SET) begin
            do_fin = 1'b1;
            f_kind = TX_UA;
          end else if (fok || finv) begin
            bad_answer_count_next = bc_inc;
            do_cont = 1'b1;
            c_st    = st_ans;
            c_ph    = PH_OR_RD;
          end else if (ftmo) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_ph    = PH_OR_RD;
          end
        end
        PH_R_RD: begin
          if (fok && item.frame_kind == RX_I) begin
            if (item.frame_seq == ctrl.rx_sequence) begin
              ctrl_next.rx_sequence = !ctrl.rx_sequence;
              do_fin = 1'b1;
              f_kind = TX_RR;
              f_seq  = !ctrl.rx_sequence;
              f_dl   = 1'b1;
            end else begin
              bad_answer_count_next = bc_inc;
              if (st_ans != ST_OK) begin
                do_fin = 1'b1;
                f_kind = TX_RR;
                f_seq  = ctrl.rx_sequence;
                f_st   = st_ans;
              end else begin
                emit          = 1'b1;
                res.send_kind = TX_RR;
                res.send_seq  = ctrl.rx_sequence;
              end
            end
          end else if (finv) begin
            bad_answer_count_next = bc_inc;
            if (st_ans != ST_OK) begin
              do_fin = 1'b1;
              f_kind = TX_REJ;
              f_seq  = ctrl.rx_sequence;
              f_st   = st_ans;
            end else begin
              emit          = 1'b1;
              res.send_kind = TX_REJ;
              res.send_seq  = ctrl.rx_sequence;
            end
          end else if (ftmo) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_ph    = PH_R_RD;
          end
        end
        PH_CR_DISC: begin
          if (fok && item.frame_kind == RX_DISC) begin
            do_cont = 1'b1;
            c_kind  = TX_DISC;
            c_ph    = PH_CR_WR;
          end else if (fok || finv) begin
            bad_answer_count_next = bc_inc;
            do_cont = 1'b1;
            c_st    = st_ans;
            c_ph    = PH_CR_DISC;
          end else if (ftmo) begin
            timeout_count_next = tc_inc;
            do_cont = 1'b1;
            c_st    = st_time;
            c_ph    = PH_CR_DISC;
          end
        end
        PH_CR_WR: begin
          if (wok) begin
            ctrl_next.phase = PH_CR_ANS;
          end else if (wfail) begin
            if (ctrl.testing_peer) begin
              do_fin = 1'b1;
            end else begin
              timeout_count_next = tc_inc;
              do_cont = 1'b1;
              c_st    = st_time;
              c_ph    = PH_CR_DISC;
            end
          end
        end
        PH_CR_ANS: begin
          if (fok && item.frame_kind == RX_UA) begin
            do_fin = 1'b1;
          end else if (fok && item.frame_kind == RX_DISC) begin
            do_cont = 1'b1;
            c_kind  = TX_DISC;
            c_ph    = PH_CR_WR;
          end else if (fok || finv) begin
            if (cfg.assume_ok) begin
              ctrl_next.testing_peer = !ctrl.testing_peer;
              do_cont = 1'b1;
              c_kind  = TX_DISC;
              c_ph    = PH_CR_WR;
            end else begin
              bad_answer_count_next = bc_inc;
              do_cont = 1'b1;
              c_st    = st_ans;
              c_ph    = PH_CR_DISC;
            end
          end else if (ftmo) begin
            if (ctrl.testing_peer) begin
              do_fin = 1'b1;
            end else begin
              timeout_count_next = tc_inc;
              do_cont = 1'b1;
              c_st    = st_time;
              c_ph    = PH_CR_DISC;
            end
          end
        end
        default: begin
          ctrl_next.phase = PH_IDLE;
        end
      endcase
    end

    // continue after a count check, or fail
    if (do_cont) begin
      if (c_st != ST_OK) begin
        do_fin = 1'b1;
        f_st   = c_st;
      end else begin
        ctrl_next.phase = c_ph;
        if (c_kind != TX_NONE) begin
          emit            = 1'b1;
          res.send_kind   = c_kind;
          res.send_seq    = c_seq;
          res.await_write = 1'b1;
        end
      end
    end

    if (do_fin) begin
      ctrl_next.phase = PH_IDLE;
      emit            = 1'b1;
      res.send_kind   = f_kind;
      res.send_seq    = f_seq;
      res.await_write = 1'b0;
      res.done_res    = 1'b1;
      res.status      = f_st;
      res.delivered   = f_dl;
    end
  end

endmodule

// File: rtl/stop_wait_link_controller.sv
// ----------------------------------------------------------------------------
// stop_wait_link_controller
// Stop-and-wait ARQ link controller: commands and link events in, frame
// requests and completion reports out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | notes
//  cmd     | in  | opcode, frame_kind, frame_seq                 | valid/ready
//  res     | out | send_kind, send_seq, await_write, done_res,   | valid/ready
//          |     | status, delivered                             | zero or one
//  cfg     | in  | cfg_we, cfg_addr, cfg_data                    | write only
//
//  One transaction per cycle unless the result register stalls; an event
//  passes the input register, then state update and result register.
//  Events that produce no result still pass through the input register.
//  A full result register that is not taken stalls the input register.
//  Reset is synchronous, clears control state and restores configuration defaults.
// ----------------------------------------------------------------------------
module stop_wait_link_controller #(
  parameter int COUNT_WIDTH = swlc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [swlc_pkg::CFG_DATA_W-1:0] cfg_data,
  swlc_stream_if.sink                     cmd,
  swlc_stream_if.source                   res
);
  import swlc_pkg::*;

  cfg_t                   cfg;
  ctrl_t                  ctrl;
  ctrl_t                  ctrl_next;
  logic [COUNT_WIDTH-1:0] timeout_count;
  logic [COUNT_WIDTH-1:0] timeout_count_next;
  logic [COUNT_WIDTH-1:0] bad_answer_count;
  logic [COUNT_WIDTH-1:0] bad_answer_count_next;

  logic    item_valid;
  item_t   item;
  logic    emit;
  result_t result_next;
  logic    res_valid;
  result_t res_data;
  logic    advance;

  assign advance   = item_valid && (!emit || !res_valid || res.ready);
  assign cmd.ready = !item_valid || advance;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role         <= 1'b0;
      cfg.time_limit   <= TIME_LIMIT_RST;
      cfg.answer_limit <= ANSWER_LIMIT_RST;
      cfg.assume_ok    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROLE:         cfg.role         <= cfg_data[0];
        REG_TIME_LIMIT:   cfg.time_limit   <= cfg_data[LIMIT_W-1:0];
        REG_ANSWER_LIMIT: cfg.answer_limit <= cfg_data[LIMIT_W-1:0];
        REG_ASSUME_OK:    cfg.assume_ok    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item <= cmd.data;
    end
  end

  swlc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .cfg                   (cfg),
    .item                  (item),
    .ctrl                  (ctrl),
    .timeout_count         (timeout_count),
    .bad_answer_count      (bad_answer_count),
    .ctrl_next             (ctrl_next),
    .timeout_count_next    (timeout_count_next),
    .bad_answer_count_next (bad_answer_count_next),
    .emit                  (emit),
    .res                   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase        <= PH_IDLE;
      ctrl.testing_peer <= 1'b0;
      ctrl.tx_sequence  <= 1'b0;
      ctrl.rx_sequence  <= 1'b0;
      timeout_count     <= '0;
      bad_answer_count  <= '0;
    end else if (advance) begin
      ctrl             <= ctrl_next;
      timeout_count    <= timeout_count_next;
      bad_answer_count <= bad_answer_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_data <= result_next;
    end
  end

endmodule
